[rtl/core/vmrq_pkg.sv]
// shared constants, codes and state type of the variable message ring queue
package vmrq_pkg;

	localparam int RING_BYTES = 4096;
	localparam int AW = $clog2(RING_BYTES);
	localparam int CW = AW + 1;
	localparam int SIZE_W = 12;
	localparam int LW = (CW > SIZE_W + 1) ? CW : SIZE_W + 1;
	localparam int CAP_MIN = 16;
	localparam int HDR_BYTES = 8;
	localparam logic [12:0] CAP_RESET = 13'd4096;

	localparam logic [1:0] REQ_SEND_HDR = 2'd0;
	localparam logic [1:0] REQ_SEND_BYTE = 2'd1;
	localparam logic [1:0] REQ_RECV = 2'd2;
	localparam logic [1:0] REQ_READ_BYTE = 2'd3;

	localparam logic [2:0] STS_OK = 3'd0;
	localparam logic [2:0] STS_NO_ROOM = 3'd1;
	localparam logic [2:0] STS_EMPTY = 3'd2;
	localparam logic [2:0] STS_CORRUPT = 3'd3;
	localparam logic [2:0] STS_IGNORED = 3'd4;

	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_FILT_EN = 2'd1;
	localparam logic [1:0] REG_FILT_TYPE = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_HDR_WR,
		ST_HDR_OFF,
		ST_HDR_RSV,
		ST_RD_CHECK,
		ST_HDR_RD,
		ST_HDR_LAST,
		ST_EVAL,
		ST_RD_OFF,
		ST_BYTE_WAIT,
		ST_RELEASE,
		ST_FIN
	} state_t;

endpackage

[rtl/core/variable_message_ring_queue.sv]
// Message ring queue over a byte-wide ring memory. Every transaction goes through one sequencer
// that owns the single-port-per-direction byte RAM and one modulo-capacity address adder, so the
// block takes one request at a time: a send header writes its eight header bytes and then makes
// two pointer updates, a read payload byte that ends the message also releases it, and a receive
// header fetches each header one byte per cycle and moves on to the next one for every message
// the type filter drops. A finished result sits in an output register, so the next request
// is taken while it waits. Writing ring_capacity empties the queue; memory contents are kept.
module variable_message_ring_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] msg_type,
	input  logic [11:0] msg_size,
	input  logic [7:0]  data_byte,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  status,
	output logic [31:0] out_type,
	output logic [11:0] out_size,
	output logic [7:0]  out_byte,
	output logic        last_byte
);

	localparam int AW = vmrq_pkg::AW;
	localparam int CW = vmrq_pkg::CW;
	localparam int LW = vmrq_pkg::LW;
	localparam int SW = vmrq_pkg::SIZE_W;

	vmrq_pkg::state_t state_q, state_d;

	// configuration
	logic [12:0] cap_q;
	logic        filt_en_q;
	logic [31:0] filt_type_q;

	// ring pointers and counts
	logic [AW-1:0] head_q, rsv_q, pub_q, wr_off_q, rd_off_q;
	logic [CW-1:0] rsv_cnt_q, pub_cnt_q, wr_rem_q, rd_rem_q;
	logic [2:0]    step_q;
	logic          rsp_valid_q;

	// latched request and working data
	logic [1:0]    req_q;
	logic [31:0]   type_q;
	logic [SW-1:0] size_q;
	logic [7:0]    data_q;
	logic [63:0]   hdr_q;
	logic [LW-1:0] mb_q;
	logic [SW-1:0] rd_size_q;

	// staged result and output register
	logic [2:0]    res_status_q, status_q;
	logic [31:0]   res_type_q, out_type_q;
	logic [SW-1:0] res_size_q, out_size_q;
	logic [7:0]    res_byte_q, out_byte_q;
	logic          res_last_q, last_byte_q;

	// effective capacity
	logic [LW-1:0] cap_ext, c_l;
	logic [CW-1:0] c;

	// shared modulo adder
	logic [AW-1:0] au_a, au_sum;
	logic [CW-1:0] au_b;
	logic [CW:0]   au_raw;

	// memory port
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	// decisions
	logic [LW-1:0] snd_mb, rsv_l, s_mb;
	logic          no_room, s_corrupt, s_short, s_drop;
	logic [63:0]   hdr_wr;
	logic [31:0]   hdr_t, hdr_s;
	logic          cfg_wr, can_load;

	assign cap_ext = LW'(cap_q);
	assign c_l = (cap_ext < LW'(vmrq_pkg::CAP_MIN)) ? LW'(vmrq_pkg::CAP_MIN) :
		((cap_ext > LW'(vmrq_pkg::RING_BYTES)) ? LW'(vmrq_pkg::RING_BYTES) : cap_ext);
	assign c = c_l[CW-1:0];

	// the offset stays below capacity and the other operand at most equal to it, so one conditional subtract wraps the sum
	assign au_raw = (CW+1)'(au_a) + (CW+1)'(au_b);
	assign au_sum = (au_raw >= (CW+1)'(c)) ? AW'(au_raw - (CW+1)'(c)) : AW'(au_raw);

	assign snd_mb = LW'(vmrq_pkg::HDR_BYTES) + LW'(size_q);
	assign rsv_l = LW'(rsv_cnt_q);
	assign no_room = (snd_mb > c_l) || (rsv_l > c_l) || (snd_mb > c_l - rsv_l);

	assign hdr_wr = {32'(size_q), type_q};
	assign hdr_t = hdr_q[31:0];
	assign hdr_s = hdr_q[63:32];
	assign s_mb = LW'(vmrq_pkg::HDR_BYTES) + LW'(hdr_s[SW-1:0]);
	assign s_corrupt = (|hdr_s[31:SW]) || (s_mb > c_l);
	assign s_short = s_mb > LW'(pub_cnt_q);
	assign s_drop = filt_en_q && (hdr_t != filt_type_q);

	assign cfg_wr = psel && penable && pwrite;
	assign can_load = !rsp_valid_q || rsp_ready;

	assign req_ready = (state_q == vmrq_pkg::ST_IDLE);
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[3:2])
			vmrq_pkg::REG_CAPACITY:  prdata = 32'(cap_q);
			vmrq_pkg::REG_FILT_EN:   prdata = 32'(filt_en_q);
			vmrq_pkg::REG_FILT_TYPE: prdata = filt_type_q;
			default:                 prdata = 32'd0;
		endcase
	end

	vmrq_ram #(
		.WIDTH(8),
		.DEPTH(vmrq_pkg::RING_BYTES)
	) u_ring (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vmrq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		au_a = head_q;
		au_b = CW'(vmrq_pkg::HDR_BYTES);
		mem_we = 1'b0;
		mem_waddr = wr_off_q;
		mem_wdata = data_q;
		mem_raddr = au_sum;
		unique case (state_q)
			vmrq_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = vmrq_pkg::ST_DECODE;
				end
			end
			vmrq_pkg::ST_DECODE: begin
				unique case (req_q)
					vmrq_pkg::REQ_SEND_HDR: begin
						if (wr_rem_q != '0 || no_room) begin
							state_d = vmrq_pkg::ST_FIN;
						end else begin
							state_d = vmrq_pkg::ST_HDR_WR;
						end
					end
					vmrq_pkg::REQ_SEND_BYTE: begin
						au_a = wr_off_q;
						au_b = CW'(1);
						mem_we = (wr_rem_q != '0);
						state_d = vmrq_pkg::ST_FIN;
					end
					vmrq_pkg::REQ_RECV: begin
						state_d = (rd_rem_q != '0) ? vmrq_pkg::ST_FIN : vmrq_pkg::ST_RD_CHECK;
					end
					vmrq_pkg::REQ_READ_BYTE: begin
						au_a = rd_off_q;
						au_b = CW'(1);
						mem_raddr = rd_off_q;
						state_d = (rd_rem_q != '0) ? vmrq_pkg::ST_BYTE_WAIT : vmrq_pkg::ST_FIN;
					end
				endcase
			end
			vmrq_pkg::ST_HDR_WR: begin
				au_a = rsv_q;
				au_b = CW'(step_q);
				mem_we = 1'b1;
				mem_waddr = au_sum;
				mem_wdata = hdr_wr[{step_q, 3'b000} +: 8];
				if (step_q == 3'd7) begin
					state_d = vmrq_pkg::ST_HDR_OFF;
				end
			end
			vmrq_pkg::ST_HDR_OFF: begin
				au_a = rsv_q;
				state_d = vmrq_pkg::ST_HDR_RSV;
			end
			vmrq_pkg::ST_HDR_RSV: begin
				au_a = rsv_q;
				au_b = mb_q[CW-1:0];
				state_d = vmrq_pkg::ST_FIN;
			end
			vmrq_pkg::ST_RD_CHECK: begin
				if (pub_cnt_q < CW'(vmrq_pkg::HDR_BYTES)) begin
					state_d = vmrq_pkg::ST_FIN;
				end else begin
					state_d = vmrq_pkg::ST_HDR_RD;
				end
			end
			vmrq_pkg::ST_HDR_RD: begin
				au_b = CW'(step_q);
				if (step_q == 3'd7) begin
					state_d = vmrq_pkg::ST_HDR_LAST;
				end
			end
			vmrq_pkg::ST_HDR_LAST: begin
				state_d = vmrq_pkg::ST_EVAL;
			end
			vmrq_pkg::ST_EVAL: begin
				if (s_corrupt || s_short) begin
					state_d = vmrq_pkg::ST_FIN;
				end else if (s_drop) begin
					state_d = vmrq_pkg::ST_RELEASE;
				end else begin
					state_d = vmrq_pkg::ST_RD_OFF;
				end
			end
			vmrq_pkg::ST_RD_OFF: begin
				state_d = vmrq_pkg::ST_FIN;
			end
			vmrq_pkg::ST_BYTE_WAIT: begin
				state_d = (rd_rem_q == '0) ? vmrq_pkg::ST_RELEASE : vmrq_pkg::ST_FIN;
			end
			vmrq_pkg::ST_RELEASE: begin
				au_b = mb_q[CW-1:0];
				// a dropped message sends the search back for the next header
				state_d = (req_q == vmrq_pkg::REQ_RECV) ? vmrq_pkg::ST_RD_CHECK : vmrq_pkg::ST_FIN;
			end
			vmrq_pkg::ST_FIN: begin
				if (can_load) begin
					state_d = vmrq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vmrq_pkg::ST_IDLE;
			end
		endcase
	end

	// pointers, counts and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= vmrq_pkg::CAP_RESET;
			filt_en_q <= 1'b0;
			filt_type_q <= '0;
			head_q <= '0;
			rsv_q <= '0;
			pub_q <= '0;
			wr_off_q <= '0;
			rd_off_q <= '0;
			rsv_cnt_q <= '0;
			pub_cnt_q <= '0;
			wr_rem_q <= '0;
			rd_rem_q <= '0;
			step_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == vmrq_pkg::ST_FIN && can_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				unique case (paddr[3:2])
					vmrq_pkg::REG_CAPACITY: begin
						cap_q <= pwdata[12:0];
						head_q <= '0;
						rsv_q <= '0;
						pub_q <= '0;
						wr_off_q <= '0;
						rd_off_q <= '0;
						rsv_cnt_q <= '0;
						pub_cnt_q <= '0;
						wr_rem_q <= '0;
						rd_rem_q <= '0;
					end
					vmrq_pkg::REG_FILT_EN:   filt_en_q <= pwdata[0];
					vmrq_pkg::REG_FILT_TYPE: filt_type_q <= pwdata;
					default: ;
				endcase
			end else begin
				unique case (state_q)
					vmrq_pkg::ST_DECODE: begin
						step_q <= '0;
						if (req_q == vmrq_pkg::REQ_SEND_BYTE && wr_rem_q != '0) begin
							wr_off_q <= au_sum;
							wr_rem_q <= wr_rem_q - CW'(1);
							if (wr_rem_q == CW'(1)) begin
								pub_q <= rsv_q;
								pub_cnt_q <= rsv_cnt_q;
							end
						end
						if (req_q == vmrq_pkg::REQ_READ_BYTE && rd_rem_q != '0) begin
							rd_off_q <= au_sum;
							rd_rem_q <= rd_rem_q - CW'(1);
						end
					end
					vmrq_pkg::ST_HDR_WR: step_q <= step_q + 3'd1;
					vmrq_pkg::ST_HDR_OFF: wr_off_q <= au_sum;
					vmrq_pkg::ST_HDR_RSV: begin
						rsv_q <= au_sum;
						rsv_cnt_q <= rsv_cnt_q + mb_q[CW-1:0];
						wr_rem_q <= CW'(size_q);
						// empty payload publishes right away
						if (size_q == '0) begin
							pub_q <= au_sum;
							pub_cnt_q <= rsv_cnt_q + mb_q[CW-1:0];
						end
					end
					vmrq_pkg::ST_RD_CHECK: step_q <= '0;
					vmrq_pkg::ST_HDR_RD: step_q <= step_q + 3'd1;
					vmrq_pkg::ST_EVAL: begin
						if (!s_corrupt && !s_short && !s_drop) begin
							rd_rem_q <= CW'(hdr_s[SW-1:0]);
						end
					end
					vmrq_pkg::ST_RD_OFF: begin
						rd_off_q <= au_sum;
						if (rd_rem_q == '0) begin
							head_q <= au_sum;
							rsv_cnt_q <= rsv_cnt_q - CW'(vmrq_pkg::HDR_BYTES);
							pub_cnt_q <= pub_cnt_q - CW'(vmrq_pkg::HDR_BYTES);
						end
					end
					vmrq_pkg::ST_RELEASE: begin
						head_q <= au_sum;
						rsv_cnt_q <= rsv_cnt_q - mb_q[CW-1:0];
						pub_cnt_q <= pub_cnt_q - mb_q[CW-1:0];
					end
					default: ;
				endcase
			end
		end
	end

	// request, header and result data
	always_ff @(posedge clk) begin
		unique case (state_q)
			vmrq_pkg::ST_IDLE: begin
				if (req_valid) begin
					req_q <= req_type;
					type_q <= msg_type;
					size_q <= msg_size;
					data_q <= data_byte;
					res_status_q <= vmrq_pkg::STS_IGNORED;
					res_type_q <= '0;
					res_size_q <= '0;
					res_byte_q <= '0;
					res_last_q <= 1'b0;
				end
			end
			vmrq_pkg::ST_DECODE: begin
				mb_q <= snd_mb;
				unique case (req_q)
					vmrq_pkg::REQ_SEND_HDR: begin
						if (wr_rem_q != '0) begin
							res_status_q <= vmrq_pkg::STS_IGNORED;
						end else if (no_room) begin
							res_status_q <= vmrq_pkg::STS_NO_ROOM;
						end else begin
							res_status_q <= vmrq_pkg::STS_OK;
						end
					end
					vmrq_pkg::REQ_SEND_BYTE: begin
						if (wr_rem_q != '0) begin
							res_status_q <= vmrq_pkg::STS_OK;
						end
					end
					vmrq_pkg::REQ_READ_BYTE: begin
						if (rd_rem_q != '0) begin
							res_status_q <= vmrq_pkg::STS_OK;
						end
					end
					default: ;
				endcase
			end
			vmrq_pkg::ST_RD_CHECK: begin
				if (pub_cnt_q < CW'(vmrq_pkg::HDR_BYTES)) begin
					res_status_q <= vmrq_pkg::STS_EMPTY;
				end
			end
			vmrq_pkg::ST_HDR_RD: begin
				// read data arrives in the cycle after its address
				if (step_q != 3'd0) begin
					hdr_q[{step_q - 3'd1, 3'b000} +: 8] <= mem_rdata;
				end
			end
			vmrq_pkg::ST_HDR_LAST: hdr_q[63:56] <= mem_rdata;
			vmrq_pkg::ST_EVAL: begin
				mb_q <= s_mb;
				if (s_corrupt) begin
					res_status_q <= vmrq_pkg::STS_CORRUPT;
				end else if (s_short) begin
					res_status_q <= vmrq_pkg::STS_EMPTY;
				end else if (!s_drop) begin
					res_status_q <= vmrq_pkg::STS_OK;
					res_type_q <= hdr_t;
					res_size_q <= hdr_s[SW-1:0];
					rd_size_q <= hdr_s[SW-1:0];
				end
			end
			vmrq_pkg::ST_BYTE_WAIT: begin
				res_byte_q <= mem_rdata;
				res_last_q <= (rd_rem_q == '0);
				mb_q <= LW'(vmrq_pkg::HDR_BYTES) + LW'(rd_size_q);
			end
			vmrq_pkg::ST_FIN: begin
				if (can_load) begin
					status_q <= res_status_q;
					out_type_q <= res_type_q;
					out_size_q <= res_size_q;
					out_byte_q <= res_byte_q;
					last_byte_q <= res_last_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign out_type = out_type_q;
	assign out_size = out_size_q;
	assign out_byte = out_byte_q;
	assign last_byte = last_byte_q;

	a_pub_within_rsv: assert property (@(posedge clk) disable iff (!arst_n)
		pub_cnt_q <= rsv_cnt_q)
		else $error("published count exceeds reserved count");

	a_rsv_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsv_cnt_q <= c)
		else $error("reserved count exceeds ring capacity");

	a_head_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < AW'(c) || c == CW'(vmrq_pkg::RING_BYTES))
		else $error("head offset outside ring");

	a_open_send_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		wr_rem_q <= rsv_cnt_q - pub_cnt_q)
		else $error("open send larger than unpublished reservation");

	a_result_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == vmrq_pkg::ST_FIN)
		else $error("result raised outside finish step");

endmodule

[rtl/core/vmrq_ram.sv]
// generic simple dual-port ram with registered read
module vmrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
